FILE: rtl/sparse_set_table_defines.svh
// ----------------------------------------------------------------------------
// sparse_set_table_defines: assertion helpers
// Shared property wrappers that use the block clock and asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef SPARSE_SET_TABLE_DEFINES_SVH
`define SPARSE_SET_TABLE_DEFINES_SVH

// invariant checked at every clock edge outside reset
`define SST_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// antecedent in this cycle implies consequent in the next
`define SST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// Types and constants shared by the sparse set table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sst_pkg;

	localparam int VALUE_W          = 7;
	localparam int POSITION_W       = 7;
	localparam int COUNT_OUT_W      = 8;
	localparam int DEF_SET_CAPACITY = 128;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_ERASE  = 2'd1,
		KIND_TEST   = 2'd2,
		KIND_READ   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_ERASE
	} state_t;

	typedef struct packed {
		kind_t                 kind;
		logic [VALUE_W-1:0]    value;
		logic [POSITION_W-1:0] position;
	} in_word_t;

	typedef struct packed {
		logic                   was_member;
		logic [VALUE_W-1:0]     element;
		logic [COUNT_OUT_W-1:0] member_count;
		logic                   out_of_range;
	} out_word_t;

endpackage

FILE: rtl/sst_stream_if.sv
// ----------------------------------------------------------------------------
// sst_stream_if
// Valid/ready channel carrying one word of type T per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sst_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/sst_ram.sv
// ----------------------------------------------------------------------------
// sst_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sst_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/sparse_set_table.sv
// Result: an accepted word waits in the execute step until the output register
//   is free, then its result word is registered there. Each word waits on the
//   registered RAM read, and a new word is taken only in the idle state; erase
//   adds an erase step, set by the two writes it makes to the single write port
//   of the map RAM. Reset: asynchronous; afterwards the map RAM is cleared one
//   entry a cycle while req.ready stays low.
// ----------------------------------------------------------------------------
// sparse_set_table
// Sparse set of small values: position map RAM indexed by value plus a dense
// member list RAM, with insert, erase, membership test and read by position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sparse_set_table_defines.svh"

module sparse_set_table import sst_pkg::*; #(
	parameter int SET_CAPACITY = DEF_SET_CAPACITY
) (
	input  logic          clk,
	input  logic          arst_n,
	sst_stream_if.sink    req,
	sst_stream_if.source  rsp
);

	localparam int IW = $clog2(SET_CAPACITY);
	localparam int CW = $clog2(SET_CAPACITY + 1);
	localparam int MW = IW + 1;

	typedef struct packed {
		logic          valid;
		logic [IW-1:0] slot;
	} map_entry_t;

	state_t             state_q, state_d;
	logic               clr_q;
	logic [IW-1:0]      clr_idx_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_next;
	in_word_t           item_q;
	logic               in_range_q;
	out_word_t          rsp_q;
	logic               rsp_valid_q;

	logic               accept;
	logic               adv;
	logic               was;
	logic               count_full;
	logic               do_insert;
	logic               do_erase;
	logic               pos_hit;

	logic               map_we, map_re;
	logic [IW-1:0]      map_waddr, map_raddr;
	map_entry_t         map_wdata, map_rdata;
	logic               dense_we, dense_re;
	logic [IW-1:0]      dense_waddr, dense_raddr;
	logic [VALUE_W-1:0] dense_wdata, dense_rdata;

	sst_ram #(.DEPTH(SET_CAPACITY), .WIDTH(MW)) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.re    (map_re),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	sst_ram #(.DEPTH(SET_CAPACITY), .WIDTH(VALUE_W)) u_dense (
		.clk   (clk),
		.we    (dense_we),
		.waddr (dense_waddr),
		.wdata (dense_wdata),
		.re    (dense_re),
		.raddr (dense_raddr),
		.rdata (dense_rdata)
	);

	// handshakes
	assign req.ready = (state_q == ST_IDLE) && !clr_q;
	assign accept    = req.valid && req.ready;
	assign adv       = !rsp_valid_q || rsp.ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// decode of the item held in the execute step
	assign was        = in_range_q && map_rdata.valid;
	assign count_full = (count_q == CW'(SET_CAPACITY));
	assign do_insert  = (item_q.kind == KIND_INSERT) && !was && in_range_q && !count_full;
	assign do_erase   = (item_q.kind == KIND_ERASE) && was && (count_q != '0);
	assign pos_hit    = int'(item_q.position) < int'(count_q);

	always_comb begin
		if (do_insert) begin
			count_next = count_q + CW'(1);
		end else if (do_erase) begin
			count_next = count_q - CW'(1);
		end else begin
			count_next = count_q;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (adv) state_d = do_erase ? ST_ERASE : ST_IDLE;
			end
			ST_ERASE: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		map_we      = 1'b0;
		map_waddr   = IW'(item_q.value);
		map_wdata   = '0;
		map_re      = 1'b0;
		map_raddr   = IW'(req.data.value);
		dense_we    = 1'b0;
		dense_waddr = IW'(count_q);
		dense_wdata = item_q.value;
		dense_re    = 1'b0;
		dense_raddr = (req.data.kind == KIND_READ) ? IW'(req.data.position)
		                                            : IW'(count_q - CW'(1));
		case (state_q)
			ST_IDLE: begin
				if (clr_q) begin
					// power-up sweep marks every value absent
					map_we    = 1'b1;
					map_waddr = clr_idx_q;
				end
				map_re   = accept;
				dense_re = accept;
			end
			ST_EXEC: begin
				if (adv && do_insert) begin
					// append value at the tail
					map_we         = 1'b1;
					map_wdata.valid = 1'b1;
					map_wdata.slot  = IW'(count_q);
					dense_we       = 1'b1;
				end else if (adv && do_erase) begin
					// move last member into the hole
					dense_we        = 1'b1;
					dense_waddr     = map_rdata.slot;
					dense_wdata     = dense_rdata;
					map_we          = 1'b1;
					map_waddr       = IW'(dense_rdata);
					map_wdata.valid = 1'b1;
					map_wdata.slot  = map_rdata.slot;
				end
			end
			ST_ERASE: begin
				// drop the erased value from the map
				map_we = 1'b1;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
			count_q   <= '0;
		end else begin
			state_q <= state_d;
			if (clr_q) begin
				if (clr_idx_q == IW'(SET_CAPACITY - 1)) clr_q <= 1'b0;
				clr_idx_q <= clr_idx_q + IW'(1);
			end
			if (state_q == ST_EXEC && adv && do_insert) begin
				count_q <= count_q + CW'(1);
			end else if (state_q == ST_ERASE) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// accepted word
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q     <= req.data;
			in_range_q <= int'(req.data.value) < SET_CAPACITY;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_EXEC && adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC && adv) begin
			rsp_q.was_member   <= was;
			rsp_q.element      <= (item_q.kind == KIND_READ && pos_hit) ? dense_rdata : '0;
			rsp_q.member_count <= COUNT_OUT_W'(count_next);
			rsp_q.out_of_range <= (item_q.kind == KIND_READ) && !pos_hit;
		end
	end

	// checks
	`SST_ASSERT_NEXT(a_accept_exec, accept, state_q == ST_EXEC, "accept did not start execute")
	`SST_ASSERT_NEXT(a_erase_shrinks, state_q == ST_ERASE,
		count_q == $past(count_q) - CW'(1), "erase did not shrink count")
	`SST_ASSERT_NEXT(a_insert_grows, state_q == ST_EXEC && adv && do_insert,
		count_q == $past(count_q) + CW'(1), "insert did not grow count")
	`SST_ASSERT(a_count_cap, count_q <= CW'(SET_CAPACITY), "count above capacity")

endmodule

FILE: sim/tb_sparse_set_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sparse_set_table
// Self-checking bench for the sparse set table. Each accepted request word is
// run through an in-bench model of the set (membership map, dense list and
// member count). The model's result word is queued and compared field by
// field with the next result word the block returns. Both channels idle and
// stall at random, and one phase holds the result side off long enough to
// back the block up.
// ----------------------------------------------------------------------------

module tb_sparse_set_table;
	import sst_pkg::*;

	localparam int SET_CAP      = DEF_SET_CAPACITY;
	localparam int RANDOM_WORDS = 1150;

	logic clk;
	logic arst_n;

	sst_stream_if #(.T(in_word_t))  req_if ();
	sst_stream_if #(.T(out_word_t)) rsp_if ();

	sparse_set_table u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// model of the set contents
	bit         in_set [SET_CAP];
	logic [7:0] slot_of [SET_CAP];
	logic [6:0] dense [SET_CAP];
	int         set_size;

	out_word_t  pending_results [$];
	int         mismatch_count;

	// idle control: steady flow shared by both sides, hold for the result side
	bit         steady_flow;
	int         rx_hold_cycles;

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit
	initial begin : run_limit
		#(5_000_000);
		$display("tb_sparse_set_table NOT OK");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	// apply one operation to the model and return the result word it yields
	function automatic out_word_t apply_set_op(in_word_t w);
		out_word_t  r;
		logic [7:0] hole;
		logic [6:0] last_val;
		r = '0;
		r.was_member = in_set[w.value];
		case (w.kind)
			KIND_INSERT: begin
				if (!in_set[w.value] && set_size < SET_CAP) begin
					in_set[w.value]  = 1'b1;
					slot_of[w.value] = set_size[7:0];
					dense[set_size]  = w.value;
					set_size++;
				end
			end
			KIND_ERASE: begin
				// last member moves into the freed slot
				if (in_set[w.value] && set_size > 0) begin
					hole              = slot_of[w.value];
					last_val          = dense[set_size - 1];
					dense[hole[6:0]]  = last_val;
					slot_of[last_val] = hole;
					in_set[w.value]   = 1'b0;
					set_size--;
				end
			end
			KIND_READ: begin
				if (int'(w.position) < set_size)
					r.element = dense[w.position];
				else
					r.out_of_range = 1'b1;
			end
			default: ;
		endcase
		r.member_count = set_size[7:0];
		return r;
	endfunction

	// offer one word after a random gap, wait for acceptance, predict
	task automatic send_word(kind_t k, logic [6:0] v, logic [6:0] p);
		int        gap;
		in_word_t  w;
		out_word_t exp_w;
		gap = steady_flow ? 0 : pick_gap();
		w.kind     = k;
		w.value    = v;
		w.position = p;
		@(negedge clk);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= w;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		exp_w = apply_set_op(w);
		pending_results = {pending_results, exp_w};
	endtask

	task automatic idle_request();
		@(negedge clk);
		req_if.valid <= 1'b0;
	endtask

	task automatic wait_results_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// result side: random stalls, or a long hold when asked for
	initial begin : result_sink
		int stall_left;
		stall_left   = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_cycles > 0) begin
				rsp_if.ready <= 1'b0;
				rx_hold_cycles--;
			end else if (steady_flow) begin
				rsp_if.ready <= 1'b1;
			end else begin
				if (stall_left == 0)
					stall_left = pick_gap();
				if (stall_left > 0) begin
					rsp_if.ready <= 1'b0;
					stall_left--;
				end else begin
					rsp_if.ready <= 1'b1;
				end
			end
		end
	end

	// compare each returned word with the oldest prediction
	always @(posedge clk) begin
		out_word_t exp_w;
		out_word_t got_w;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got_w = rsp_if.data;
			if (pending_results.size() == 0) begin
				$error("unexpected result word %h", got_w);
				mismatch_count++;
			end else begin
				exp_w = pending_results.pop_front();
				if (got_w.was_member !== exp_w.was_member) begin
					$error("was_member: expected %0d, got %0d",
						exp_w.was_member, got_w.was_member);
					mismatch_count++;
				end
				if (got_w.element !== exp_w.element) begin
					$error("element: expected %0d, got %0d",
						exp_w.element, got_w.element);
					mismatch_count++;
				end
				if (got_w.member_count !== exp_w.member_count) begin
					$error("member_count: expected %0d, got %0d",
						exp_w.member_count, got_w.member_count);
					mismatch_count++;
				end
				if (got_w.out_of_range !== exp_w.out_of_range) begin
					$error("out_of_range: expected %0d, got %0d",
						exp_w.out_of_range, got_w.out_of_range);
					mismatch_count++;
				end
			end
		end
	end

	// extremes and corner cases of each operation
	task automatic test_directed();
		send_word(KIND_READ, 7'd0, 7'd0);       // read on an empty set
		send_word(KIND_READ, 7'd127, 7'd127);
		send_word(KIND_TEST, 7'd0, 7'd0);
		send_word(KIND_ERASE, 7'd127, 7'd0);    // erase of an absent value
		send_word(KIND_INSERT, 7'd0, 7'd127);
		send_word(KIND_INSERT, 7'd127, 7'd0);
		send_word(KIND_INSERT, 7'd0, 7'd0);     // insert of a member
		send_word(KIND_TEST, 7'd0, 7'd0);
		send_word(KIND_TEST, 7'd127, 7'd0);
		send_word(KIND_TEST, 7'd64, 7'd0);
		send_word(KIND_READ, 7'd127, 7'd0);     // read still reports membership
		send_word(KIND_READ, 7'd5, 7'd1);
		send_word(KIND_READ, 7'd0, 7'd2);       // just past the count
		send_word(KIND_ERASE, 7'd0, 7'd0);      // last member fills the hole
		send_word(KIND_READ, 7'd0, 7'd0);
		send_word(KIND_ERASE, 7'd127, 7'd0);    // erase of the only member
		send_word(KIND_ERASE, 7'd127, 7'd0);
		send_word(KIND_INSERT, 7'd85, 7'd42);
		send_word(KIND_INSERT, 7'd42, 7'd85);
		send_word(KIND_ERASE, 7'd42, 7'd0);     // erase of the last member
		send_word(KIND_READ, 7'd42, 7'd0);
		send_word(KIND_READ, 7'd42, 7'd1);
		send_word(KIND_ERASE, 7'd85, 7'd0);
	endtask

	// fill to capacity in random order, probe, then empty again
	task automatic test_fill_and_empty();
		logic [6:0] order [SET_CAP];
		logic [6:0] tmp;
		int         j;
		for (int i = 0; i < SET_CAP; i++)
			order[i] = i[6:0];
		for (int i = SET_CAP - 1; i > 0; i--) begin
			j        = $urandom_range(0, i);
			tmp      = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int i = 0; i < SET_CAP; i++)
			send_word(KIND_INSERT, order[i], 7'($urandom_range(0, 127)));
		send_word(KIND_INSERT, order[3], 7'd0);  // full set, already a member
		send_word(KIND_READ, 7'd127, 7'd127);
		send_word(KIND_READ, 7'd0, 7'd0);
		send_word(KIND_TEST, 7'd127, 7'd0);
		for (int i = 0; i < SET_CAP; i++)
			send_word(KIND_ERASE, order[(i * 37) % SET_CAP], 7'd0);
		send_word(KIND_READ, 7'd0, 7'd0);
	endtask

	// hold off results while the sender keeps pushing, then pause to drain
	task automatic test_backpressure();
		steady_flow    = 1'b1;
		rx_hold_cycles = 80;
		for (int i = 0; i < 24; i++)
			send_word((i % 3 == 0) ? KIND_READ : KIND_INSERT,
				7'($urandom_range(0, 127)), 7'($urandom_range(0, 7)));
		idle_request();
		wait_results_drained();
		steady_flow = 1'b0;
	endtask

	// mostly valid traffic aimed at members, with drifting insert bias
	task automatic test_random();
		int         r;
		int         insert_pct;
		kind_t      k;
		logic [6:0] v;
		logic [6:0] p;
		insert_pct = 50;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 100 == 0)
				insert_pct = $urandom_range(20, 65);
			steady_flow = (n >= 300 && n < 450);
			r = $urandom_range(0, 99);
			if (r < insert_pct)
				k = KIND_INSERT;
			else if (r < insert_pct + 20)
				k = KIND_ERASE;
			else if (r < insert_pct + 27)
				k = KIND_TEST;
			else
				k = KIND_READ;
			v = 7'($urandom_range(0, 127));
			p = 7'($urandom_range(0, 127));
			// aim erases and tests at current members most of the time
			if ((k == KIND_ERASE || k == KIND_TEST) && set_size > 0
					&& $urandom_range(0, 99) < 70)
				v = dense[$urandom_range(0, set_size - 1)];
			if (k == KIND_READ && $urandom_range(0, 99) < 80)
				p = 7'($urandom_range(0, (set_size < SET_CAP) ? set_size : SET_CAP - 1));
			send_word(k, v, p);
		end
		steady_flow = 1'b0;
	endtask

	// main sequence
	initial begin
		arst_n         = 1'b0;
		req_if.valid   = 1'b0;
		req_if.data    = '0;
		steady_flow    = 1'b0;
		rx_hold_cycles = 0;
		mismatch_count = 0;
		set_size       = 0;
		for (int i = 0; i < SET_CAP; i++) begin
			in_set[i]  = 1'b0;
			slot_of[i] = '0;
			dense[i]   = '0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_fill_and_empty();
		test_backpressure();
		test_random();

		idle_request();
		wait_results_drained();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_sparse_set_table OK");
		else
			$display("tb_sparse_set_table NOT OK");
		$finish;
	end

endmodule
